### rtl/core/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// shared constants and types of the chained hash table engine
// ----------------------------------------------------------------------------
package chte_pkg;
	localparam int BUCKETS       = 4096;
	localparam int POOL_ENTRIES  = 2048;
	localparam int TOTAL_ENTRIES = BUCKETS + POOL_ENTRIES;
	localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
	localparam int BKT_W         = $clog2(BUCKETS);
	localparam int POOL_W        = $clog2(POOL_ENTRIES + 1);
	localparam int LINK_W        = 14;
	localparam int KEY_BYTES     = 8;
	localparam int KEY_W         = 8 * KEY_BYTES;
	localparam int LEN_W         = 4;
	localparam int VAL_W         = 32;
	localparam int NB_W          = 13;
	localparam int HASH_W        = 32;
	localparam logic [HASH_W-1:0] DJB_SEED  = 32'd5381;
	localparam logic [LINK_W-1:0] LINK_FREE = '0;
	localparam logic [LINK_W-1:0] LINK_END  = '1;

	localparam logic [2:0] REQ_INS_ABSENT  = 3'd0;
	localparam logic [2:0] REQ_INS_REPLACE = 3'd1;
	localparam logic [2:0] REQ_APPEND      = 3'd2;
	localparam logic [2:0] REQ_FIND        = 3'd3;
	localparam logic [2:0] REQ_FIND_NEXT   = 3'd4;
	localparam logic [2:0] REQ_CLEAR       = 3'd5;

	localparam logic CFG_BUCKET_COUNT = 1'b0;
	localparam logic CFG_FOLD_CASE    = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  len;
		logic [VAL_W-1:0]  value;
		logic [LINK_W-1:0] link;
	} entry_t;
endpackage

### rtl/core/chte_hashmod.sv
// ----------------------------------------------------------------------------
// chte_hashmod
// iterative key hash (one byte a cycle) and bucket modulo (one bit a cycle)
// ----------------------------------------------------------------------------
module chte_hashmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [chte_pkg::KEY_W-1:0]   key,
	input  logic [chte_pkg::LEN_W-1:0]   len,
	input  logic [chte_pkg::NB_W-1:0]    nb,
	output logic                         done,
	output logic [chte_pkg::BKT_W-1:0]   bucket
);
	import chte_pkg::*;

	typedef enum logic [1:0] {H_IDLE, H_HASH, H_DIV} hstate_t;

	hstate_t             state_q;
	logic [HASH_W-1:0]   h_q;
	logic [KEY_W-1:0]    key_q;
	logic [LEN_W-1:0]    left_q;
	logic [NB_W-1:0]     nb_q;
	logic [BKT_W-1:0]    rem_q;
	logic [4:0]          cnt_q;
	logic                done_q;
	logic [NB_W-1:0]     trial;
	logic [HASH_W-1:0]   h_next;

	assign trial  = {rem_q, h_q[HASH_W-1]};
	assign h_next = ((h_q << 5) + h_q) ^ {{(HASH_W-8){key_q[7]}}, key_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
			h_q     <= '0;
			key_q   <= '0;
			left_q  <= '0;
			nb_q    <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						h_q     <= DJB_SEED;
						key_q   <= key;
						left_q  <= len;
						nb_q    <= nb;
						state_q <= H_HASH;
					end
				end
				H_HASH: begin
					if (left_q == '0) begin
						rem_q   <= '0;
						cnt_q   <= '1;
						state_q <= H_DIV;
					end else begin
						h_q    <= h_next;
						key_q  <= key_q >> 8;
						left_q <= left_q - 1'b1;
					end
				end
				H_DIV: begin
					// restoring division, remainder only
					if (trial >= nb_q)
						rem_q <= BKT_W'(trial - nb_q);
					else
						rem_q <= trial[BKT_W-1:0];
					h_q   <= h_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;
endmodule

### rtl/core/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// hash table with chained overflow entries: insert, append, find, find next and clear
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// found, value_out and status with done high for exactly one cycle, and the
// receiver cannot stall it. A request runs through the hash/modulo unit (one
// key byte, then one hash bit a cycle), then reads and checks each chain entry
// visited over the single read port of the entry memory, and writes one more
// link when an overflow entry is linked in; find next skips the hash. A clear
// request, and the pass after reset, sweeps all 6144 entries at one a cycle,
// and busy stays high during the sweep.
module chained_hash_table_engine_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [2:0]         req_type,
	input  logic [63:0]        key_bytes,
	input  logic [3:0]         key_len,
	input  logic signed [31:0] new_value,
	output logic               found,
	output logic signed [31:0] value_out,
	output logic               status,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [12:0]        cfg_data
);
	import chte_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_LINK} state_t;

	state_t              state_q;
	logic [NB_W-1:0]     bucket_count_q;
	logic                fold_case_q;
	logic [2:0]          req_q;
	logic [KEY_W-1:0]    key_q;
	logic [LEN_W-1:0]    len_q;
	logic [VAL_W-1:0]    nval_q;
	logic [ADDR_W-1:0]   cur_q;
	logic [ADDR_W-1:0]   last_addr_q;
	entry_t              last_q;
	logic [ADDR_W-1:0]   new_addr_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [POOL_W-1:0]   pool_fill_q;
	logic [LINK_W-1:0]   resume_q;
	logic [KEY_W-1:0]    saved_key_q;
	logic [LEN_W-1:0]    saved_len_q;
	logic                done_q;
	logic                found_q;
	logic [VAL_W-1:0]    value_q;
	logic                status_q;

	entry_t              mem_q [TOTAL_ENTRIES];
	entry_t              rdata_q;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	entry_t              wdata;

	logic [LEN_W-1:0]    in_len;
	logic [KEY_W-1:0]    in_key;
	logic [NB_W-1:0]     nb;
	logic                hm_start;
	logic                hm_done;
	logic [BKT_W-1:0]    hm_bucket;
	logic                is_free;
	logic                is_end;
	logic                is_match;
	logic                pool_full;
	logic [ADDR_W-1:0]   pool_addr;

	// clamp length, fold case and zero unused bytes
	always_comb begin
		in_len = (key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_len;
		for (int i = 0; i < KEY_BYTES; i++) begin
			in_key[8*i +: 8] = (LEN_W'(i) < in_len) ? key_bytes[8*i +: 8] : 8'h00;
			if (fold_case_q && in_key[8*i +: 8] >= 8'h41 && in_key[8*i +: 8] <= 8'h5a)
				in_key[8*i +: 8] = in_key[8*i +: 8] + 8'h20;
		end
	end

	always_comb begin
		if (bucket_count_q == '0)
			nb = NB_W'(1);
		else if (bucket_count_q > NB_W'(BUCKETS))
			nb = NB_W'(BUCKETS);
		else
			nb = bucket_count_q;
	end

	assign hm_start = (state_q == S_IDLE) && start && (req_type <= REQ_FIND);

	chte_hashmod u_hashmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hm_start),
		.key    (in_key),
		.len    (in_len),
		.nb     (nb),
		.done   (hm_done),
		.bucket (hm_bucket)
	);

	assign is_free   = (rdata_q.link == LINK_FREE);
	assign is_end    = (rdata_q.link == LINK_END);
	assign is_match  = (rdata_q.len == len_q) && (rdata_q.key == key_q);
	assign pool_full = (pool_fill_q >= POOL_W'(POOL_ENTRIES));
	assign pool_addr = ADDR_W'(BUCKETS) + ADDR_W'(pool_fill_q);

	// write port of the entry memory
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = '{key: key_q, len: len_q, value: nval_q, link: LINK_END};
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = '0;
			end
			S_CHECK: begin
				if (req_q <= REQ_APPEND) begin
					if (is_free) begin
						we = 1'b1;
					end else if (req_q != REQ_APPEND && is_match) begin
						we          = (req_q == REQ_INS_REPLACE);
						wdata       = rdata_q;
						wdata.value = nval_q;
					end else if (is_end && !pool_full) begin
						we    = 1'b1;
						waddr = pool_addr;
					end
				end
			end
			S_LINK: begin
				we         = 1'b1;
				waddr      = last_addr_q;
				wdata      = last_q;
				wdata.link = LINK_W'(new_addr_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			bucket_count_q <= NB_W'(BUCKETS);
			fold_case_q    <= 1'b0;
			req_q          <= '0;
			key_q          <= '0;
			len_q          <= '0;
			nval_q         <= '0;
			cur_q          <= '0;
			last_addr_q    <= '0;
			last_q         <= '0;
			new_addr_q     <= '0;
			clr_cnt_q      <= '0;
			pool_fill_q    <= '0;
			resume_q       <= '0;
			saved_key_q    <= '0;
			saved_len_q    <= '0;
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			value_q        <= '0;
			status_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BUCKET_COUNT: bucket_count_q <= cfg_data;
					CFG_FOLD_CASE:    fold_case_q    <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == ADDR_W'(TOTAL_ENTRIES - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= S_IDLE;
						if (req_q == REQ_CLEAR) begin
							done_q   <= 1'b1;
							found_q  <= 1'b0;
							value_q  <= '0;
							status_q <= 1'b0;
						end
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q    <= req_type;
						// find next continues with the key of the last find that matched
						key_q    <= (req_type == REQ_FIND_NEXT) ? saved_key_q : in_key;
						len_q    <= (req_type == REQ_FIND_NEXT) ? saved_len_q : in_len;
						nval_q   <= new_value;
						found_q  <= 1'b0;
						value_q  <= '0;
						status_q <= 1'b0;
						if (req_type <= REQ_FIND) begin
							state_q <= S_HASH;
						end else if (req_type == REQ_FIND_NEXT) begin
							if (resume_q == '0) begin
								done_q <= 1'b1;
							end else begin
								cur_q   <= resume_q[ADDR_W-1:0];
								state_q <= S_READ;
							end
						end else if (req_type == REQ_CLEAR) begin
							pool_fill_q <= '0;
							resume_q    <= '0;
							state_q     <= S_CLEAR;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_HASH: begin
					if (hm_done) begin
						cur_q   <= ADDR_W'(hm_bucket);
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (req_q <= REQ_APPEND) begin
						if (is_free) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (req_q != REQ_APPEND && is_match) begin
							found_q <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (is_end) begin
							if (pool_full) begin
								status_q <= 1'b1;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								pool_fill_q <= pool_fill_q + 1'b1;
								new_addr_q  <= pool_addr;
								last_addr_q <= cur_q;
								last_q      <= rdata_q;
								state_q     <= S_LINK;
							end
						end else begin
							cur_q   <= rdata_q.link[ADDR_W-1:0];
							state_q <= S_READ;
						end
					end else begin
						if (is_free) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (is_match) begin
							found_q  <= 1'b1;
							value_q  <= rdata_q.value;
							resume_q <= is_end ? LINK_FREE : rdata_q.link;
							if (req_q == REQ_FIND) begin
								saved_key_q <= key_q;
								saved_len_q <= len_q;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (is_end) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							cur_q   <= rdata_q.link[ADDR_W-1:0];
							state_q <= S_READ;
						end
					end
				end
				S_LINK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign found     = found_q;
	assign value_out = value_q;
	assign status    = status_q;

	// a result always leaves the block ready for the next item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		status |-> !found && value_q == '0)
		else $error("refused insert reports a match");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_fill_q <= POOL_W'(POOL_ENTRIES))
		else $error("pool fill past pool size");

	a_pool_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |-> $past(state_q) == S_CHECK && !$past(pool_full))
		else $error("link write without free pool entry");
endmodule
